// ===== rtl/core/arp_icmp_echo_responder_unit_defines.svh =====
// ----------------------------------------------------------------------------
// ARP and ICMP echo responder assertion macros
// Concurrent assertion forms used by the responder top module.
// ----------------------------------------------------------------------------
`ifndef ARP_ICMP_ECHO_RESPONDER_UNIT_DEFINES_SVH
`define ARP_ICMP_ECHO_RESPONDER_UNIT_DEFINES_SVH

// An implication that must hold at every clock edge outside reset.
`define AIER_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define AIER_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== rtl/core/aier_pkg.sv =====
// ----------------------------------------------------------------------------
// ARP and ICMP echo responder package
// Types, protocol constants and byte helpers shared by the responder modules.
// ----------------------------------------------------------------------------
package aier_pkg;

  localparam int MAX_FRAME_DEFAULT = 512;
  localparam int MIN_PAYLOAD       = 46;
  localparam int ETH_HDR           = 14;
  localparam int MIN_REPLY         = ETH_HDR + MIN_PAYLOAD;
  localparam int MIN_FRAME         = 42;
  localparam int LEN_W             = 10;

  localparam logic [15:0] ETYPE_ARP     = 16'h0806;
  localparam logic [15:0] ETYPE_IP      = 16'h0800;
  localparam logic [15:0] ARP_OP_REQUEST = 16'd1;
  localparam logic [15:0] ARP_OP_REPLY   = 16'd2;
  localparam logic [15:0] ARP_HTYPE_ETH  = 16'd1;
  localparam logic [7:0]  ARP_HLEN       = 8'd6;
  localparam logic [7:0]  ARP_PLEN       = 8'd4;
  localparam logic [7:0]  IP_PROTO_ICMP  = 8'd1;
  localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'd8;
  localparam logic [7:0]  ICMP_ECHO_REPLY   = 8'd0;
  localparam logic [7:0]  ICMP_CODE_ECHO    = 8'd0;
  localparam logic [7:0]  BCAST_BYTE        = 8'hff;
  localparam logic [15:0] SUM_VALID         = 16'hffff;

  localparam logic KIND_ARP  = 1'b0;
  localparam logic KIND_ICMP = 1'b1;

  typedef enum logic [1:0] {
    ST_RX,
    ST_JUDGE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic        arp_ok;
    logic        icmp_ok;
    logic [15:0] ip_csum;
    logic [15:0] icmp_csum;
  } chk_t;

  typedef struct packed {
    logic             start;
    logic             kind;
    logic [LEN_W-1:0] rlen;
    logic [LEN_W-1:0] flen;
    logic [15:0]      ip_csum;
    logic [15:0]      icmp_csum;
  } tx_cmd_t;

  function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] k);
    logic [47:0] sh;
    sh = mac >> (8 * (5 - int'(k)));
    return sh[7:0];
  endfunction

  function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] k);
    logic [31:0] sh;
    sh = ip >> (8 * (3 - int'(k)));
    return sh[7:0];
  endfunction

  // ARP header bytes 14 to 21 for a request (reply differs in the opcode).
  function automatic logic [7:0] arp_hdr_byte(input logic [2:0] k, input logic [15:0] op);
    logic [7:0] b;
    case (k)
      3'd0: b = ARP_HTYPE_ETH[15:8];
      3'd1: b = ARP_HTYPE_ETH[7:0];
      3'd2: b = ETYPE_IP[15:8];
      3'd3: b = ETYPE_IP[7:0];
      3'd4: b = ARP_HLEN;
      3'd5: b = ARP_PLEN;
      3'd6: b = op[15:8];
      default: b = op[7:0];
    endcase
    return b;
  endfunction

  // Ones' complement add with end-around carry.
  function automatic logic [15:0] ones_add(input logic [15:0] s, input logic [15:0] a);
    logic [16:0] t;
    t = {1'b0, s} + {1'b0, a};
    return t[15:0] + {15'd0, t[16]};
  endfunction

endpackage

// ===== rtl/core/arp_icmp_echo_responder_unit.sv =====
// ----------------------------------------------------------------------------
// ARP and ICMP echo responder
// Stores a received frame and answers ARP requests and ICMP echo requests.
// ----------------------------------------------------------------------------
// Usage: received frame bytes enter on the s_ stream, one byte per beat, with
// s_tlast on the final byte. Bytes are taken at one per cycle. The cycle after
// the last beat the frame is judged; s_tready stays low while judging and while
// a reply is read out. An ARP request for our IP gets a 60-byte ARP reply; an
// ICMP echo request to our MAC and IP with good checksums gets an echo reply
// as long as the request (at least 60 bytes). Other frames, and frames longer
// than MAX_FRAME bytes, are dropped, and s_tready returns the cycle after.
// Replies leave on the m_ stream as 64-bit words, first byte on top, with the
// valid byte count beside them. The reply is read out one byte per cycle
// through the single read port of the frame store while the output is not
// stalled; s_tready returns once the last word is loaded and the state
// machine has left ST_EMIT. A stalled receiver holds the output word and
// stops the read-out until it is taken.
// Reset clears counters, flags and the output valid; our_mac and our_ip reset
// to zero and are written over the APB port at addresses 0x0 and 0x8.
// ----------------------------------------------------------------------------
`include "arp_icmp_echo_responder_unit_defines.svh"

module arp_icmp_echo_responder_unit #(
  parameter int MAX_FRAME = aier_pkg::MAX_FRAME_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tlast,   // rx_last
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [63:0] tx_word, [67:64] tx_bytes, rest zero
  output logic        m_tlast,   // tx_last
  output logic        m_tuser,   // [0] reply_kind
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MAX_FRAME);
  localparam int LW = aier_pkg::LEN_W;

  aier_pkg::state_t  state, state_next;
  aier_pkg::chk_t    chk;
  aier_pkg::tx_cmd_t cmd;

  logic [47:0]   our_mac;
  logic [31:0]   our_ip;
  logic [LW-1:0] byte_count, flen;
  logic          too_long, flen_long;
  logic          beat, store, tx_busy;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          len_ok, send_arp, send_icmp;

  // Configuration registers. Bit 3 of the address selects the register.
  assign pready = 1'b1;
  assign prdata = paddr[3] ? {32'd0, our_ip} : {16'd0, our_mac};

  always_ff @(posedge clk) begin
    if (rst) begin
      our_mac <= 48'd0;
      our_ip  <= 32'd0;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[3]) begin
        our_ip <= pwdata[31:0];
      end else begin
        our_mac <= pwdata[47:0];
      end
    end
  end

  // Bytes past the store depth are not kept; the frame is then marked long.
  assign beat  = s_tvalid && s_tready;
  assign store = beat && (byte_count < LW'(MAX_FRAME));

  aier_frame_mem #(.DEPTH(MAX_FRAME), .AW(AW)) u_mem (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr (byte_count[AW-1:0]),
    .wr_data (s_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  aier_check #(.AW(AW)) u_check (
    .clk     (clk),
    .rst     (rst),
    .we      (store),
    .idx     (byte_count[AW-1:0]),
    .din     (s_tdata),
    .our_mac (our_mac),
    .our_ip  (our_ip),
    .chk     (chk)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= aier_pkg::ST_RX;
      byte_count <= '0;
      too_long   <= 1'b0;
      flen_long  <= 1'b0;
    end else begin
      state <= state_next;
      if (beat) begin
        if (s_tlast) begin
          byte_count <= '0;
          too_long   <= 1'b0;
          flen_long  <= too_long | !store;
        end else if (store) begin
          byte_count <= byte_count + LW'(1);
        end else begin
          too_long <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (beat && s_tlast) begin
      flen <= byte_count + LW'(store);
    end
  end

  // Judge step: the checker flags are settled the cycle after the last byte.
  assign len_ok    = !flen_long && (flen >= LW'(aier_pkg::MIN_FRAME));
  assign send_arp  = len_ok && chk.arp_ok;
  assign send_icmp = len_ok && !chk.arp_ok && chk.icmp_ok;

  always_comb begin
    state_next = state;
    case (state)
      aier_pkg::ST_RX: begin
        if (beat && s_tlast) begin
          state_next = aier_pkg::ST_JUDGE;
        end
      end
      aier_pkg::ST_JUDGE: begin
        state_next = (send_arp || send_icmp) ? aier_pkg::ST_EMIT : aier_pkg::ST_RX;
      end
      aier_pkg::ST_EMIT: begin
        if (!tx_busy) begin
          state_next = aier_pkg::ST_RX;
        end
      end
      default: begin
        state_next = aier_pkg::ST_RX;
      end
    endcase
  end

  always_comb begin
    s_tready      = 1'b0;
    cmd.start     = 1'b0;
    cmd.kind      = send_icmp ? aier_pkg::KIND_ICMP : aier_pkg::KIND_ARP;
    cmd.flen      = flen;
    cmd.rlen      = (send_icmp && flen > LW'(aier_pkg::MIN_REPLY)) ?
                    flen : LW'(aier_pkg::MIN_REPLY);
    cmd.ip_csum   = chk.ip_csum;
    cmd.icmp_csum = chk.icmp_csum;
    case (state)
      aier_pkg::ST_RX: begin
        s_tready = 1'b1;
      end
      aier_pkg::ST_JUDGE: begin
        cmd.start = send_arp || send_icmp;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  aier_tx #(.AW(AW)) u_tx (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .our_mac  (our_mac),
    .our_ip   (our_ip),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .busy     (tx_busy),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  // The store must never take bytes while a reply is being read from it.
  `AIER_NEVER(a_no_rx_during_tx, s_tready && tx_busy, "input taken during reply read-out")
  // Only the final word of a reply may be short.
  `AIER_ASSERT(a_full_words, m_tvalid && !m_tlast |-> m_tdata[67:64] == 4'd8, "short inner word")
  // A started reply keeps the emitter busy in the next cycle.
  `AIER_ASSERT(a_start_busy, cmd.start |=> tx_busy, "emitter did not start")
  // A judged frame never claims more bytes than the store holds.
  `AIER_ASSERT(a_len_bound, state == aier_pkg::ST_JUDGE |-> flen <= LW'(MAX_FRAME),
    "frame length beyond store")

endmodule

// ===== rtl/core/aier_frame_mem.sv =====
// ----------------------------------------------------------------------------
// Frame store
// Byte memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module aier_frame_mem #(
  parameter int DEPTH = aier_pkg::MAX_FRAME_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/aier_check.sv =====
// ----------------------------------------------------------------------------
// Frame checker
// Matches header bytes and accumulates checksums as bytes are stored.
// ----------------------------------------------------------------------------
module aier_check #(
  parameter int AW = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               we,
  input  logic [AW-1:0]      idx,
  input  logic [7:0]         din,
  input  logic [47:0]        our_mac,
  input  logic [31:0]        our_ip,
  output aier_pkg::chk_t     chk
);

  logic f_bcast, f_dmac, f_et_arp, f_et_ip, f_arp_hdr, f_tip, f_proto, f_dip, f_type;
  logic f_bcast_next, f_dmac_next, f_et_arp_next, f_et_ip_next, f_arp_hdr_next;
  logic f_tip_next, f_proto_next, f_dip_next, f_type_next;
  logic [15:0] ip_all, ip_oth, ic_all, ic_oth;
  logic [15:0] ip_all_next, ip_oth_next, ic_all_next, ic_oth_next;

  always_comb begin
    logic [aier_pkg::LEN_W-1:0] ix;
    logic        first;
    logic [15:0] add;
    ix    = aier_pkg::LEN_W'(idx);
    first = (ix == '0);
    add   = ix[0] ? {8'h00, din} : {din, 8'h00};

    f_bcast_next   = first ? 1'b1 : f_bcast;
    f_dmac_next    = first ? 1'b1 : f_dmac;
    f_et_arp_next  = first ? 1'b1 : f_et_arp;
    f_et_ip_next   = first ? 1'b1 : f_et_ip;
    f_arp_hdr_next = first ? 1'b1 : f_arp_hdr;
    f_tip_next     = first ? 1'b1 : f_tip;
    f_proto_next   = first ? 1'b1 : f_proto;
    f_dip_next     = first ? 1'b1 : f_dip;
    f_type_next    = first ? 1'b1 : f_type;
    ip_all_next    = first ? 16'd0 : ip_all;
    ip_oth_next    = first ? 16'd0 : ip_oth;
    ic_all_next    = first ? 16'd0 : ic_all;
    ic_oth_next    = first ? 16'd0 : ic_oth;

    if (ix < aier_pkg::LEN_W'(6)) begin
      f_bcast_next = f_bcast_next & (din == aier_pkg::BCAST_BYTE);
      f_dmac_next  = f_dmac_next & (din == aier_pkg::mac_byte(our_mac, 3'(ix)));
    end
    if (ix == aier_pkg::LEN_W'(12)) begin
      f_et_arp_next = f_et_arp_next & (din == aier_pkg::ETYPE_ARP[15:8]);
      f_et_ip_next  = f_et_ip_next & (din == aier_pkg::ETYPE_IP[15:8]);
    end
    if (ix == aier_pkg::LEN_W'(13)) begin
      f_et_arp_next = f_et_arp_next & (din == aier_pkg::ETYPE_ARP[7:0]);
      f_et_ip_next  = f_et_ip_next & (din == aier_pkg::ETYPE_IP[7:0]);
    end
    if (ix >= aier_pkg::LEN_W'(14) && ix < aier_pkg::LEN_W'(22)) begin
      f_arp_hdr_next = f_arp_hdr_next &
        (din == aier_pkg::arp_hdr_byte(3'(ix - aier_pkg::LEN_W'(14)), aier_pkg::ARP_OP_REQUEST));
    end
    if (ix >= aier_pkg::LEN_W'(38) && ix < aier_pkg::LEN_W'(42)) begin
      f_tip_next = f_tip_next &
        (din == aier_pkg::ip_byte(our_ip, 2'(ix - aier_pkg::LEN_W'(38))));
    end
    if (ix >= aier_pkg::LEN_W'(30) && ix < aier_pkg::LEN_W'(34)) begin
      f_dip_next = f_dip_next &
        (din == aier_pkg::ip_byte(our_ip, 2'(ix - aier_pkg::LEN_W'(30))));
    end
    if (ix == aier_pkg::LEN_W'(23)) begin
      f_proto_next = f_proto_next & (din == aier_pkg::IP_PROTO_ICMP);
    end
    if (ix == aier_pkg::LEN_W'(34)) begin
      f_type_next = f_type_next & (din == aier_pkg::ICMP_ECHO_REQUEST);
    end
    if (ix == aier_pkg::LEN_W'(35)) begin
      f_type_next = f_type_next & (din == aier_pkg::ICMP_CODE_ECHO);
    end

    // IP header words are 14..33, the checksum field is 24..25.
    if (ix >= aier_pkg::LEN_W'(14) && ix < aier_pkg::LEN_W'(34)) begin
      ip_all_next = aier_pkg::ones_add(ip_all_next, add);
      if (ix != aier_pkg::LEN_W'(24) && ix != aier_pkg::LEN_W'(25)) begin
        ip_oth_next = aier_pkg::ones_add(ip_oth_next, add);
      end
    end
    // The reply clears type, code and checksum, so its sum starts at byte 38.
    if (ix >= aier_pkg::LEN_W'(34)) begin
      ic_all_next = aier_pkg::ones_add(ic_all_next, add);
    end
    if (ix >= aier_pkg::LEN_W'(38)) begin
      ic_oth_next = aier_pkg::ones_add(ic_oth_next, add);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_bcast   <= 1'b0;
      f_dmac    <= 1'b0;
      f_et_arp  <= 1'b0;
      f_et_ip   <= 1'b0;
      f_arp_hdr <= 1'b0;
      f_tip     <= 1'b0;
      f_proto   <= 1'b0;
      f_dip     <= 1'b0;
      f_type    <= 1'b0;
    end else if (we) begin
      f_bcast   <= f_bcast_next;
      f_dmac    <= f_dmac_next;
      f_et_arp  <= f_et_arp_next;
      f_et_ip   <= f_et_ip_next;
      f_arp_hdr <= f_arp_hdr_next;
      f_tip     <= f_tip_next;
      f_proto   <= f_proto_next;
      f_dip     <= f_dip_next;
      f_type    <= f_type_next;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      ip_all <= ip_all_next;
      ip_oth <= ip_oth_next;
      ic_all <= ic_all_next;
      ic_oth <= ic_oth_next;
    end
  end

  assign chk.arp_ok    = f_bcast & f_et_arp & f_arp_hdr & f_tip;
  assign chk.icmp_ok   = f_dmac & f_et_ip & f_dip & f_proto & f_type &
                         (ip_all == aier_pkg::SUM_VALID) & (ic_all == aier_pkg::SUM_VALID);
  assign chk.ip_csum   = ~ip_oth;
  assign chk.icmp_csum = ~ic_oth;

endmodule

// ===== rtl/core/aier_tx.sv =====
// ----------------------------------------------------------------------------
// Reply emitter
// Reads stored bytes, one a cycle unless stalled, edits them into reply words.
// ----------------------------------------------------------------------------
module aier_tx #(
  parameter int AW = 9
) (
  input  logic                clk,
  input  logic                rst,
  input  aier_pkg::tx_cmd_t   cmd,
  input  logic [47:0]         our_mac,
  input  logic [31:0]         our_ip,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr,
  input  logic [7:0]          rd_data,
  output logic                busy,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [71:0]         m_tdata,
  output logic                m_tlast,
  output logic                m_tuser
);

  localparam int LW = aier_pkg::LEN_W;

  logic          kind;
  logic [LW-1:0] rlen, flen, p_iss, p_rd;
  logic [15:0]   ipc, icc;
  logic          rd_valid;
  logic [63:0]   acc, word_cur, m_word;
  logic [2:0]    acc_cnt;
  logic [3:0]    m_bytes;
  logic          issue, word_done, is_end, out_free, adv;
  logic [LW-1:0] addr;
  logic [7:0]    cur;

  assign issue     = busy && (p_iss < rlen);
  assign is_end    = (p_rd == rlen - LW'(1));
  assign word_done = rd_valid && ((acc_cnt == 3'd7) || is_end);
  assign out_free  = !m_tvalid || m_tready;
  assign adv       = !word_done || out_free;
  assign rd_en     = adv && issue;
  assign rd_addr   = addr[AW-1:0];

  // Where in the stored frame each reply byte comes from.
  always_comb begin
    addr = p_iss;
    if (kind == aier_pkg::KIND_ARP) begin
      if (p_iss < LW'(6)) begin
        addr = p_iss + LW'(22);
      end else begin
        addr = p_iss - LW'(10);
      end
    end else begin
      if (p_iss < LW'(6)) begin
        addr = p_iss + LW'(6);
      end else if (p_iss >= LW'(30) && p_iss < LW'(34)) begin
        addr = p_iss - LW'(4);
      end
    end
  end

  always_comb begin
    cur = rd_data;
    if (kind == aier_pkg::KIND_ARP) begin
      if (p_rd < LW'(6)) begin
        cur = rd_data;
      end else if (p_rd < LW'(12)) begin
        cur = aier_pkg::mac_byte(our_mac, 3'(p_rd - LW'(6)));
      end else if (p_rd == LW'(12)) begin
        cur = aier_pkg::ETYPE_ARP[15:8];
      end else if (p_rd == LW'(13)) begin
        cur = aier_pkg::ETYPE_ARP[7:0];
      end else if (p_rd < LW'(22)) begin
        cur = aier_pkg::arp_hdr_byte(3'(p_rd - LW'(14)), aier_pkg::ARP_OP_REPLY);
      end else if (p_rd < LW'(28)) begin
        cur = aier_pkg::mac_byte(our_mac, 3'(p_rd - LW'(22)));
      end else if (p_rd < LW'(32)) begin
        cur = aier_pkg::ip_byte(our_ip, 2'(p_rd - LW'(28)));
      end else if (p_rd < LW'(42)) begin
        cur = rd_data;
      end else begin
        cur = 8'h00;
      end
    end else begin
      if (p_rd >= flen) begin
        cur = 8'h00;
      end else if (p_rd < LW'(6)) begin
        cur = rd_data;
      end else if (p_rd < LW'(12)) begin
        cur = aier_pkg::mac_byte(our_mac, 3'(p_rd - LW'(6)));
      end else if (p_rd == LW'(12)) begin
        cur = aier_pkg::ETYPE_IP[15:8];
      end else if (p_rd == LW'(13)) begin
        cur = aier_pkg::ETYPE_IP[7:0];
      end else if (p_rd == LW'(24)) begin
        cur = ipc[15:8];
      end else if (p_rd == LW'(25)) begin
        cur = ipc[7:0];
      end else if (p_rd >= LW'(26) && p_rd < LW'(30)) begin
        cur = aier_pkg::ip_byte(our_ip, 2'(p_rd - LW'(26)));
      end else if (p_rd == LW'(34)) begin
        cur = aier_pkg::ICMP_ECHO_REPLY;
      end else if (p_rd == LW'(35)) begin
        cur = aier_pkg::ICMP_CODE_ECHO;
      end else if (p_rd == LW'(36)) begin
        cur = icc[15:8];
      end else if (p_rd == LW'(37)) begin
        cur = icc[7:0];
      end
    end
  end

  assign word_cur = acc | ({56'd0, cur} << {3'(3'd7 - acc_cnt), 3'b000});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rd_valid <= 1'b0;
      acc_cnt  <= 3'd0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.start) begin
        busy     <= 1'b1;
        rd_valid <= 1'b0;
        acc_cnt  <= 3'd0;
      end else if (adv) begin
        rd_valid <= issue;
        if (rd_valid) begin
          acc_cnt <= word_done ? 3'd0 : acc_cnt + 3'd1;
          if (is_end) begin
            busy <= 1'b0;
          end
        end
      end
      if (adv && word_done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind  <= cmd.kind;
      rlen  <= cmd.rlen;
      flen  <= cmd.flen;
      ipc   <= cmd.ip_csum;
      icc   <= cmd.icmp_csum;
      p_iss <= '0;
      acc   <= 64'd0;
    end else if (adv) begin
      if (issue) begin
        p_iss <= p_iss + LW'(1);
      end
      p_rd <= p_iss;
      if (rd_valid) begin
        acc <= word_done ? 64'd0 : word_cur;
      end
    end
    if (adv && word_done) begin
      m_word  <= word_cur;
      m_bytes <= 4'({1'b0, acc_cnt} + 4'd1);
      m_tlast <= is_end;
      m_tuser <= kind;
    end
  end

  assign m_tdata = {4'd0, m_bytes, m_word};

endmodule

// ===== test/arp_icmp_echo_responder_unit_tb.sv =====
// ----------------------------------------------------------------------------
// ARP and ICMP echo responder testbench
// Sends Ethernet frames byte by byte into the responder. The frames are ARP
// requests, ICMP echo requests, broken variants, noise and short frames.
// Every reply word is checked against a predictor of the expected replies
// under several MAC/IP settings, with random gaps on both streams.
// ----------------------------------------------------------------------------
module arp_icmp_echo_responder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_CAP = 512;
  localparam int DRAIN_CYCLES = 30;
  localparam logic [3:0] ADDR_MAC = 4'h0;
  localparam logic [3:0] ADDR_IP  = 4'h8;

  typedef enum int {
    FR_ARP, FR_ICMP, FR_NOISE, FR_SHORT, FR_BAD_IPSUM, FR_BAD_ICMPSUM,
    FR_NOT_ECHO, FR_WRONG_IP, FR_ARP_UNICAST, FR_OVERSIZE
  } frame_kind_e;

  typedef struct {
    frame_kind_e kind;
    int          len;
    int          words;   // expected reply words, -1 where the predictor decides
  } frame_row_t;

  typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
    logic        kind;
  } reply_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [7:0] rx_byte
  logic        s_tlast = 1'b0; // rx_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // [63:0] tx_word, [67:64] tx_bytes
  logic        m_tlast;        // tx_last
  logic        m_tuser;        // [0] reply_kind
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  arp_icmp_echo_responder_unit u_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor copies of the registers and of the frame being received.
  logic [47:0] mac_q;
  logic [31:0] ip_q;
  logic [7:0]  rx_frame[$];
  logic        rx_too_long = 1'b0;
  reply_word_t reply_q[$];
  int          mismatches = 0;
  logic [7:0]  fb[$];   // frame under construction by the generator

  function automatic logic [15:0] inet_csum(input logic [7:0] d[$], input int off,
                                            input int n);
    logic [31:0] s;
    s = 0;
    for (int i = 0; i + 1 < n; i += 2) s += {d[off+i], d[off+i+1]};
    if (n % 2) s += {d[off+n-1], 8'h00};
    while (s[31:16] != 0) s = s[31:16] + s[15:0];
    return ~s[15:0];
  endfunction

  function automatic logic [7:0] mac_at(input logic [47:0] m, input int k);
    return m[47-8*k -: 8];
  endfunction

  function automatic logic [7:0] ip_at(input logic [31:0] a, input int k);
    return a[31-8*k -: 8];
  endfunction

  // Judges the finished frame and queues the reply words; returns their number.
  function automatic int predict_reply();
    logic [7:0]  q[$];
    logic [7:0]  tx[$];
    logic [15:0] c;
    logic        kind;
    logic        mac_bcast, mac_ours, ip_tgt, ip_dst;
    int          len, rlen, nw;
    q = rx_frame;
    len = q.size();
    rlen = 0;
    kind = aier_pkg::KIND_ARP;
    nw = 0;
    if (!rx_too_long && len >= aier_pkg::MIN_FRAME) begin
      mac_bcast = 1'b1;
      mac_ours = 1'b1;
      ip_tgt = 1'b1;
      ip_dst = 1'b1;
      for (int i = 0; i < 6; i++) begin
        if (q[i] != aier_pkg::BCAST_BYTE) mac_bcast = 1'b0;
        if (q[i] != mac_at(mac_q, i)) mac_ours = 1'b0;
      end
      for (int i = 0; i < 4; i++) begin
        if (q[38+i] != ip_at(ip_q, i)) ip_tgt = 1'b0;
        if (q[30+i] != ip_at(ip_q, i)) ip_dst = 1'b0;
      end
      if ({q[12], q[13]} == aier_pkg::ETYPE_ARP && mac_bcast &&
          {q[14], q[15]} == aier_pkg::ARP_HTYPE_ETH &&
          {q[16], q[17]} == aier_pkg::ETYPE_IP && q[18] == aier_pkg::ARP_HLEN &&
          q[19] == aier_pkg::ARP_PLEN &&
          {q[20], q[21]} == aier_pkg::ARP_OP_REQUEST && ip_tgt) begin
        rlen = aier_pkg::MIN_REPLY;
        for (int i = 0; i < rlen; i++) tx.push_back(8'h00);
        for (int i = 0; i < 6; i++) begin
          tx[i] = q[22+i];
          tx[6+i] = mac_at(mac_q, i);
          tx[22+i] = mac_at(mac_q, i);
        end
        tx[12] = aier_pkg::ETYPE_ARP[15:8]; tx[13] = aier_pkg::ETYPE_ARP[7:0];
        tx[15] = aier_pkg::ARP_HTYPE_ETH[7:0]; tx[16] = aier_pkg::ETYPE_IP[15:8];
        tx[18] = aier_pkg::ARP_HLEN; tx[19] = aier_pkg::ARP_PLEN;
        tx[21] = aier_pkg::ARP_OP_REPLY[7:0];
        for (int i = 0; i < 4; i++) tx[28+i] = ip_at(ip_q, i);
        for (int i = 0; i < 10; i++) tx[32+i] = q[22+i];
        kind = aier_pkg::KIND_ARP;
      end else if ({q[12], q[13]} == aier_pkg::ETYPE_IP && mac_ours && ip_dst &&
                   inet_csum(q, 14, 20) == 16'h0 && q[23] == aier_pkg::IP_PROTO_ICMP &&
                   inet_csum(q, 34, len - 34) == 16'h0 &&
                   q[34] == aier_pkg::ICMP_ECHO_REQUEST &&
                   q[35] == aier_pkg::ICMP_CODE_ECHO) begin
        rlen = len < aier_pkg::MIN_REPLY ? aier_pkg::MIN_REPLY : len;
        for (int i = 0; i < rlen; i++) tx.push_back(8'h00);
        for (int i = 0; i < 6; i++) begin
          tx[i] = q[6+i];
          tx[6+i] = mac_at(mac_q, i);
        end
        tx[12] = aier_pkg::ETYPE_IP[15:8]; tx[13] = aier_pkg::ETYPE_IP[7:0];
        for (int i = 14; i < len; i++) tx[i] = q[i];
        // Swap the IP addresses: our IP becomes the source.
        for (int i = 0; i < 4; i++) begin
          tx[26+i] = ip_at(ip_q, i);
          tx[30+i] = q[26+i];
        end
        tx[24] = 0; tx[25] = 0;
        c = inet_csum(tx, 14, 20);
        tx[24] = c[15:8]; tx[25] = c[7:0];
        tx[34] = aier_pkg::ICMP_ECHO_REPLY; tx[35] = 0; tx[36] = 0; tx[37] = 0;
        c = inet_csum(tx, 34, len - 34);
        tx[36] = c[15:8]; tx[37] = c[7:0];
        kind = aier_pkg::KIND_ICMP;
      end
    end
    for (int off = 0; off < rlen; off += 8) begin
      reply_word_t r;
      r.nbytes = (rlen - off < 8) ? 4'(rlen - off) : 4'd8;
      r.word = '0;
      for (int i = 0; i < r.nbytes; i++) r.word[63-8*i -: 8] = tx[off+i];
      r.last = (off + 8 >= rlen);
      r.kind = kind;
      reply_q.push_back(r);
      nw++;
    end
    rx_frame.delete();
    rx_too_long = 1'b0;
    return nw;
  endfunction

  // Builds a frame of the given kind into fb.
  task automatic build_frame(input frame_kind_e kind, input int len);
    logic [15:0] c;
    fb.delete();
    for (int i = 0; i < len; i++) fb.push_back(8'($urandom_range(0, 255)));
    case (kind)
      FR_ARP, FR_ARP_UNICAST: begin
        for (int i = 0; i < 6; i++)
          fb[i] = (kind == FR_ARP) ? aier_pkg::BCAST_BYTE : mac_at(mac_q, i);
        fb[12] = aier_pkg::ETYPE_ARP[15:8]; fb[13] = aier_pkg::ETYPE_ARP[7:0];
        fb[14] = aier_pkg::ARP_HTYPE_ETH[15:8]; fb[15] = aier_pkg::ARP_HTYPE_ETH[7:0];
        fb[16] = aier_pkg::ETYPE_IP[15:8]; fb[17] = aier_pkg::ETYPE_IP[7:0];
        fb[18] = aier_pkg::ARP_HLEN; fb[19] = aier_pkg::ARP_PLEN;
        fb[20] = aier_pkg::ARP_OP_REQUEST[15:8]; fb[21] = aier_pkg::ARP_OP_REQUEST[7:0];
        for (int i = 0; i < 4; i++) fb[38+i] = ip_at(ip_q, i);
      end
      FR_ICMP, FR_BAD_IPSUM, FR_BAD_ICMPSUM, FR_NOT_ECHO, FR_WRONG_IP, FR_SHORT: begin
        for (int i = 0; i < 6 && i < len; i++) fb[i] = mac_at(mac_q, i);
        if (len >= aier_pkg::MIN_FRAME) begin
          fb[12] = aier_pkg::ETYPE_IP[15:8]; fb[13] = aier_pkg::ETYPE_IP[7:0];
          fb[23] = aier_pkg::IP_PROTO_ICMP;
          for (int i = 0; i < 4; i++) fb[30+i] = ip_at(ip_q, i);
          // A timestamp request stands in for a type that is not an echo request.
          fb[34] = (kind == FR_NOT_ECHO) ? 8'd13 : aier_pkg::ICMP_ECHO_REQUEST;
          fb[35] = aier_pkg::ICMP_CODE_ECHO;
          fb[24] = 0; fb[25] = 0;
          c = inet_csum(fb, 14, 20);
          fb[24] = c[15:8]; fb[25] = c[7:0];
          fb[36] = 0; fb[37] = 0;
          c = inet_csum(fb, 34, len - 34);
          fb[36] = c[15:8]; fb[37] = c[7:0];
          if (kind == FR_BAD_IPSUM) fb[24] ^= 8'h01;
          if (kind == FR_BAD_ICMPSUM) fb[37] ^= 8'h40;
          if (kind == FR_WRONG_IP) fb[33] ^= 8'h80;
        end
      end
      default: ;
    endcase
  endtask

  // Sends one byte; a gap may come first. The predictor sees it on acceptance.
  task automatic send_byte(input logic [7:0] b, input logic last, input bit steady);
    int gap;
    gap = 0;
    if (!steady && $urandom_range(0, 5) == 0)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    if (rx_frame.size() < FRAME_CAP) rx_frame.push_back(b);
    else rx_too_long = 1'b1;
  endtask

  task automatic send_frame(input int expected_words);
    int  nw;
    bit  steady;
    steady = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < fb.size(); i++) send_byte(fb[i], i == fb.size() - 1, steady);
    nw = predict_reply();
    if (expected_words >= 0 && nw != expected_words) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Reply length mismatch: expected %0d words, predicted %0d",
                 expected_words, nw);
    end
  endtask

  // Waits until all replies have been taken and the block has settled.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    s_tlast <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, access cycle, then idle before the next transfer.
  task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_MAC) mac_q = data[47:0];
    else ip_q = data[31:0];
    @(posedge clk);
  endtask

  task automatic set_addresses(input logic [47:0] m, input logic [31:0] a);
    apb_write(ADDR_MAC, {16'h0, m});
    apb_write(ADDR_IP, {32'h0, a});
    @(posedge clk);
  endtask

  // Reply side: random stalls, mostly short, and checks of every accepted beat.
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (reply_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected reply beat: word=%h bytes=%0d", m_tdata[63:0],
                     m_tdata[67:64]);
        end else begin
          reply_word_t r;
          r = reply_q.pop_front();
          if (m_tdata[63:0] !== r.word || m_tdata[67:64] !== r.nbytes ||
              m_tlast !== r.last || m_tuser !== r.kind) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Reply mismatch: expected %h/%0d/%b/%b, got %h/%0d/%b/%b",
                       r.word, r.nbytes, r.last, r.kind, m_tdata[63:0],
                       m_tdata[67:64], m_tlast, m_tuser);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                  : $urandom_range(0, 2);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // The directed frames: shortest replies of both kinds and a frame one byte short.
  frame_row_t directed[] = '{
    '{FR_ARP,         42,  8},
    '{FR_ICMP,        43,  -1},   // odd ICMP length
    '{FR_SHORT,       41,  0}
  };

  initial begin
    int sent;
    int r;
    mac_q = '0;
    ip_q = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames with random addresses.
    set_addresses({$urandom, $urandom}, $urandom);
    foreach (directed[i]) begin
      build_frame(directed[i].kind, directed[i].len);
      send_frame(directed[i].words);
    end
    wait_drained();

    // Random frames, each setting in turn, including both extremes.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_addresses(48'h0, 32'h0);
        1: set_addresses(48'hffff_ffff_ffff, 32'hffff_ffff);
        default: set_addresses({$urandom, $urandom}, $urandom);
      endcase
      sent = 0;
      while (sent < 30) begin
        r = $urandom_range(0, 9);
        if (r < 4) build_frame(FR_ICMP, $urandom_range(42, 64));
        else if (r < 7) build_frame(FR_ARP, $urandom_range(42, 64));
        else if (r == 7) build_frame(FR_NOISE, $urandom_range(1, 60));
        else if (r == 8) build_frame(frame_kind_e'($urandom_range(FR_BAD_IPSUM,
                                     FR_ARP_UNICAST)), $urandom_range(42, 64));
        else build_frame(FR_SHORT, $urandom_range(1, 41));
        sent += fb.size();
        send_frame(-1);
        // Now and then hold off until every reply has been taken.
        if ($urandom_range(0, 5) == 0) begin
          s_tvalid <= 1'b0;
          @(posedge clk);
          while (reply_q.size() != 0) @(posedge clk);
        end
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/aier_pkg.sv
rtl/core/aier_frame_mem.sv
rtl/core/aier_check.sv
rtl/core/aier_tx.sv
rtl/core/arp_icmp_echo_responder_unit.sv
test/arp_icmp_echo_responder_unit_tb.sv
